// ----- rtl/mi2d_pkg.sv -----
// Shared types, constants and helpers for the two-dimensional map interpolator.
`timescale 1ns / 1ps
package mi2d_pkg;

   localparam int DATA_W       = 32;
   localparam int FUNC_W       = 3;
   localparam int PIDX_W       = 4;
   localparam int CNT_W        = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int FRAC_W       = 31;
   localparam int PROD_W       = DATA_W + FRAC_W;
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;

   localparam logic [FUNC_W-1:0] FUNC_LD_SPEED = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LD_CMD   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LD_CELL  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INVERSE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FORWARD  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   // Which store a read addresses.
   typedef enum logic [1:0] {
      SRC_SPD,
      SRC_CMD,
      SRC_COL,
      SRC_GRID
   } src_type;

   // Datapath operations, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_MM_INIT,
      OP_MM_UPD,
      OP_CLAMP_SPEED,
      OP_CLAMP_QIN,
      OP_SET_Q,
      OP_K1,
      OP_K0,
      OP_DIV_START,
      OP_LOAD_A,
      OP_LOAD_B,
      OP_MUL,
      OP_ADD,
      OP_WR_COL,
      OP_RES_Y,
      OP_RES_SAT,
      OP_RES_LOAD,
      OP_RES_NONE,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type  op;
      src_type src;
   } dp_cmd_type;

   typedef struct packed {
      logic rd_lt_q;
      logic q_lt_rd;
      logic cls_a;
      logic cls_b;
      logic div_done;
   } dp_stat_type;

   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ----- rtl/map_interpolator_2d_core.sv -----
// Top level of the two-dimensional acceleration map interpolator.
// The block keeps a grid of accelerations indexed by command breakpoint (rows)
// and speed breakpoint (columns), together with both breakpoint lists.
// Each transfer on the req_ channel is either a load of one breakpoint or cell,
// or a query: forward (command to acceleration) or inverse (acceleration to command).
// Every request, unused codes included, produces exactly one transfer on the rsp_ channel.
// The csr_ port sets how many rows and columns are in use; write it only while idle.
// One request is handled at a time. A load writes its store in a result state, then
// a done state moves the result into the output register.
// A query scans the keys for their range, searches the segment, runs a 31-step divider
// at most once per pass, then interpolates each row; the final pass along the rows
// repeats that pattern for one row, but an inverse query checks the column ends for
// saturation instead of scanning keys. The longest case is a forward query that needs
// the divider in both passes and the deepest segment search.
// A finished result sits in an output register, so the next request is accepted
// while the previous result waits; a new result only waits if that register is full.
// Synchronous reset clears the row and column counts to zero and empties the output;
// map contents are undefined until written.
`timescale 1ns / 1ps
module map_interpolator_2d_core
   import mi2d_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [PIDX_W-1:0]        req_row,
   input  logic [PIDX_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0] req_load_data,
   input  logic signed [DATA_W-1:0] req_query_speed,
   input  logic signed [DATA_W-1:0] req_query_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_ok,
   output logic                     rsp_saturated,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CNT_W-1:0]         csr_wdata
);

   localparam int CW = idx_width(MAX_COLS);
   localparam int RW = idx_width(MAX_ROWS);
   localparam int IW = (CW > RW) ? CW : RW;
   localparam int NW = IW + 1;

   dp_cmd_type    cmd;
   dp_stat_type   stat;
   logic [IW-1:0] rd_addr;
   logic [RW-1:0] rd_row;
   logic [NW-1:0] nr, nc;

   // The controller owns sequencing and the handshakes; the datapath owns all storage.
   mi2d_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .nr        (nr),
      .nc        (nc),
      .stat      (stat),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .rd_row    (rd_row)
   );

   mi2d_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_load_data   (req_load_data),
      .req_query_speed (req_query_speed),
      .req_query_in    (req_query_in),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .rd_row          (rd_row),
      .stat            (stat),
      .nr              (nr),
      .nc              (nc),
      .rsp_result      (rsp_result),
      .rsp_ok          (rsp_ok),
      .rsp_saturated   (rsp_saturated)
   );

`ifndef SYNTHESIS
   // An accepted request always takes the block out of idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block did not go busy");

   // A new result only appears at the end of a request's processing.
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a request in flight");

   // A saturated answer is always an answered query.
   a_sat_implies_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> rsp_ok)
      else $error("saturated flag without ok");
`endif

endmodule

// ----- rtl/mi2d_div.sv -----
// Restoring divider that forms the Q0.31 segment fraction one bit per cycle.
`timescale 1ns / 1ps
module mi2d_div
   import mi2d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] num,
   input  logic [DATA_W-1:0] den,
   output logic              done,
   output logic [FRAC_W-1:0] quot
);

   localparam int STEP_W = $clog2(FRAC_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [FRAC_W-1:0] quot_ff, quot_in;
   logic [DATA_W:0]   shifted;
   logic              fits;

   // The remainder always stays below the divisor, so one shift and one
   // compare-subtract give the next quotient bit.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? DATA_W'(shifted - {1'b0, den_ff}) : DATA_W'(shifted);
         quot_in = {quot_ff[FRAC_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/mi2d_dp.sv -----
// Datapath: breakpoint, grid and column stores, arithmetic registers and result registers.
`timescale 1ns / 1ps
module mi2d_dp
   import mi2d_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   localparam int CW = idx_width(MAX_COLS),
   localparam int RW = idx_width(MAX_ROWS),
   localparam int IW = (CW > RW) ? CW : RW,
   localparam int NW = IW + 1
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [PIDX_W-1:0]        req_row,
   input  logic [PIDX_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0] req_load_data,
   input  logic signed [DATA_W-1:0] req_query_speed,
   input  logic signed [DATA_W-1:0] req_query_in,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CNT_W-1:0]         csr_wdata,
   input  dp_cmd_type               cmd,
   input  logic [IW-1:0]            rd_addr,
   input  logic [RW-1:0]            rd_row,
   output dp_stat_type              stat,
   output logic [NW-1:0]            nr,
   output logic [NW-1:0]            nc,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_ok,
   output logic                     rsp_saturated
);

   localparam int GD = MAX_ROWS * MAX_COLS;
   localparam int GW = idx_width(GD);
   localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

   logic signed [DATA_W-1:0] spd_mem [MAX_COLS];
   logic signed [DATA_W-1:0] cmd_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] col_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] grid_mem [GD];

   logic signed [DATA_W-1:0] spd_rd_ff, cmd_rd_ff, col_rd_ff, grid_rd_ff;
   src_type                  src_ff;
   logic signed [DATA_W-1:0] rd_data;

   logic [CNT_W-1:0]         rows_ff, cols_ff;
   logic [FUNC_W-1:0]        func_ff;
   logic [PIDX_W-1:0]        row_ff, col_ff;
   logic signed [DATA_W-1:0] data_ff, speed_ff, qin_ff;

   logic signed [DATA_W-1:0] q_ff, lo_ff, hi_ff, k0_ff, k1_ff, a_ff, b_ff, y_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     neg_ff;
   logic signed [DATA_W-1:0] res_ff;
   logic                     ok_ff, sat_ff;
   logic signed [DATA_W-1:0] rsp_result_ff;
   logic                     rsp_ok_ff, rsp_sat_ff;

   logic signed [DATA_W:0]   num_w, den_w, diff_w, mag_w;
   logic [PROD_W:0]          rnd_w;
   logic [DATA_W-1:0]        p_w;
   logic [FRAC_W-1:0]        quot;
   logic                     div_done;
   logic                     col_ok, row_ok, load_ok;
   logic [GW:0]              grid_ra_w, grid_wa_w;

   function automatic logic signed [DATA_W-1:0] clamp(
      input logic signed [DATA_W-1:0] v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi
   );
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Counts above the store depth behave as the full depth.
   assign nr = (32'(rows_ff) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_ff);
   assign nc = (32'(cols_ff) > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_ff);

   assign col_ok = 32'(col_ff) < MAX_COLS;
   assign row_ok = 32'(row_ff) < MAX_ROWS;

   always_comb begin
      case (func_ff)
         FUNC_LD_SPEED: load_ok = col_ok;
         FUNC_LD_CMD:   load_ok = row_ok;
         FUNC_LD_CELL:  load_ok = col_ok && row_ok;
         default:       load_ok = 1'b0;
      endcase
   end

   assign grid_ra_w = (GW + 1)'(rd_row) * (GW + 1)'(MAX_COLS) + (GW + 1)'(CW'(rd_addr));
   assign grid_wa_w = (GW + 1)'(row_ff) * (GW + 1)'(MAX_COLS) + (GW + 1)'(col_ff);

   // Stores: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RES_LOAD && func_ff == FUNC_LD_SPEED && col_ok) begin
         spd_mem[CW'(col_ff)] <= data_ff;
      end
      spd_rd_ff <= spd_mem[CW'(rd_addr)];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RES_LOAD && func_ff == FUNC_LD_CMD && row_ok) begin
         cmd_mem[RW'(row_ff)] <= data_ff;
      end
      cmd_rd_ff <= cmd_mem[RW'(rd_addr)];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WR_COL) begin
         col_mem[rd_row] <= y_ff;
      end
      col_rd_ff <= col_mem[RW'(rd_addr)];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RES_LOAD && func_ff == FUNC_LD_CELL && load_ok) begin
         grid_mem[grid_wa_w[GW-1:0]] <= data_ff;
      end
      grid_rd_ff <= grid_mem[grid_ra_w[GW-1:0]];
   end

   always_comb begin
      case (src_ff)
         SRC_SPD:  rd_data = spd_rd_ff;
         SRC_CMD:  rd_data = cmd_rd_ff;
         SRC_COL:  rd_data = col_rd_ff;
         SRC_GRID: rd_data = grid_rd_ff;
         default:  rd_data = spd_rd_ff;
      endcase
   end

   // Segment arithmetic.
   assign num_w  = {q_ff[DATA_W-1], q_ff} - {k0_ff[DATA_W-1], k0_ff};
   assign den_w  = {k1_ff[DATA_W-1], k1_ff} - {k0_ff[DATA_W-1], k0_ff};
   assign diff_w = {b_ff[DATA_W-1], b_ff} - {a_ff[DATA_W-1], a_ff};
   assign mag_w  = diff_w[DATA_W] ? -diff_w : diff_w;
   assign rnd_w  = {1'b0, prod_ff} + HALF;
   assign p_w    = rnd_w[PROD_W-1:FRAC_W];

   mi2d_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_DIV_START),
      .num   (num_w[DATA_W-1:0]),
      .den   (den_w[DATA_W-1:0]),
      .done  (div_done),
      .quot  (quot)
   );

   assign stat.rd_lt_q  = rd_data < q_ff;
   assign stat.q_lt_rd  = q_ff < rd_data;
   assign stat.cls_a    = (den_w <= 0) || (num_w <= 0);
   assign stat.cls_b    = num_w >= den_w;
   assign stat.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         cols_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default:  rows_ff <= rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            func_ff  <= req_func;
            row_ff   <= req_row;
            col_ff   <= req_col;
            data_ff  <= req_load_data;
            speed_ff <= req_query_speed;
            qin_ff   <= req_query_in;
         end
         OP_MM_INIT: begin
            lo_ff <= rd_data;
            hi_ff <= rd_data;
         end
         OP_MM_UPD: begin
            if (rd_data < lo_ff) lo_ff <= rd_data;
            if (rd_data > hi_ff) hi_ff <= rd_data;
         end
         OP_CLAMP_SPEED: q_ff <= clamp(speed_ff, lo_ff, hi_ff);
         OP_CLAMP_QIN:   q_ff <= clamp(qin_ff, lo_ff, hi_ff);
         OP_SET_Q:       q_ff <= qin_ff;
         OP_K1:          k1_ff <= rd_data;
         OP_K0:          k0_ff <= rd_data;
         OP_LOAD_A: begin
            a_ff <= rd_data;
            y_ff <= rd_data;
         end
         OP_LOAD_B: begin
            b_ff <= rd_data;
            y_ff <= rd_data;
         end
         OP_MUL: begin
            prod_ff <= mag_w[DATA_W-1:0] * quot;
            neg_ff  <= diff_w[DATA_W];
         end
         OP_ADD: y_ff <= neg_ff ? a_ff - $signed(p_w) : a_ff + $signed(p_w);
         OP_RES_Y: begin
            res_ff <= y_ff;
            ok_ff  <= 1'b1;
            sat_ff <= 1'b0;
         end
         OP_RES_SAT: begin
            res_ff <= rd_data;
            ok_ff  <= 1'b1;
            sat_ff <= 1'b1;
         end
         OP_RES_LOAD: begin
            res_ff <= '0;
            ok_ff  <= load_ok;
            sat_ff <= 1'b0;
         end
         OP_RES_NONE: begin
            res_ff <= '0;
            ok_ff  <= 1'b0;
            sat_ff <= 1'b0;
         end
         OP_OUT: begin
            rsp_result_ff <= res_ff;
            rsp_ok_ff     <= ok_ff;
            rsp_sat_ff    <= sat_ff;
         end
         default: begin
         end
      endcase
      src_ff <= cmd.src;
   end

   assign rsp_result    = rsp_result_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- rtl/mi2d_ctrl.sv -----
// Controller: sequences clamping, segment search, division and row interpolation.
`timescale 1ns / 1ps
module mi2d_ctrl
   import mi2d_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   localparam int CW = idx_width(MAX_COLS),
   localparam int RW = idx_width(MAX_ROWS),
   localparam int IW = (CW > RW) ? CW : RW,
   localparam int NW = IW + 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [NW-1:0]     nr,
   input  logic [NW-1:0]     nc,
   input  dp_stat_type       stat,
   output dp_cmd_type        cmd,
   output logic [IW-1:0]     rd_addr,
   output logic [RW-1:0]     rd_row
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_NONE, ST_MM_RD, ST_MM_USE, ST_CLAMP,
      ST_SEG_START, ST_SEG_RD, ST_SEG_CHK, ST_SEG_RD0, ST_SEG_K0, ST_SEG_CLS,
      ST_DIV, ST_AP_RDA, ST_AP_A, ST_AP_RDB, ST_AP_B, ST_AP_MUL, ST_AP_ADD,
      ST_AP_WR, ST_INV0, ST_INV0_CHK, ST_INV1, ST_INV1_CHK, ST_SAT_RD,
      ST_SAT_RES, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_A,
      MODE_B,
      MODE_T
   } mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              final_ff, final_in;
   src_type           ks_ff, ks_in, vs_ff, vs_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     r_ff, r_in;
   logic [IW-1:0]     i_ff, i_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]     n_w, i_ext, i_p1, i_p2;

   // The first pass works along the speed keys, the final one along the rows.
   assign n_w   = final_ff ? nr : nc;
   assign i_ext = NW'(i_ff);
   assign i_p1  = i_ext + NW'(1);
   assign i_p2  = i_ext + NW'(2);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      func_in      = func_ff;
      final_in     = final_ff;
      ks_in        = ks_ff;
      vs_in        = vs_ff;
      idx_in       = idx_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.src      = SRC_SPD;
      rd_addr      = '0;
      rd_row       = RW'(r_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               func_in  = req_func;
               final_in = 1'b0;
               idx_in   = '0;
               ks_in    = SRC_SPD;
               vs_in    = SRC_GRID;
               if (req_func inside {FUNC_LD_SPEED, FUNC_LD_CMD, FUNC_LD_CELL}) begin
                  state_in = ST_LOAD;
               end else if (req_func inside {FUNC_INVERSE, FUNC_FORWARD} &&
                            nr != '0 && nc != '0) begin
                  state_in = ST_MM_RD;
               end else begin
                  state_in = ST_NONE;
               end
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_RES_LOAD;
            state_in = ST_DONE;
         end
         ST_NONE: begin
            cmd.op   = OP_RES_NONE;
            state_in = ST_DONE;
         end
         ST_MM_RD: begin
            cmd.src  = ks_ff;
            rd_addr  = IW'(idx_ff);
            state_in = ST_MM_USE;
         end
         ST_MM_USE: begin
            cmd.op   = (idx_ff == '0) ? OP_MM_INIT : OP_MM_UPD;
            idx_in   = idx_ff + 1'b1;
            state_in = ((idx_ff + 1'b1) < n_w) ? ST_MM_RD : ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op   = final_ff ? OP_CLAMP_QIN : OP_CLAMP_SPEED;
            state_in = ST_SEG_START;
         end
         ST_SEG_START: begin
            i_in = '0;
            r_in = '0;
            if (n_w == NW'(1)) begin
               mode_in  = MODE_A;
               state_in = ST_AP_RDA;
            end else begin
               state_in = ST_SEG_RD;
            end
         end
         ST_SEG_RD: begin
            cmd.src  = ks_ff;
            rd_addr  = IW'(i_p1);
            state_in = ST_SEG_CHK;
         end
         ST_SEG_CHK: begin
            if (i_p2 < n_w && stat.rd_lt_q) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SEG_RD;
            end else begin
               cmd.op   = OP_K1;
               state_in = ST_SEG_RD0;
            end
         end
         ST_SEG_RD0: begin
            cmd.src  = ks_ff;
            rd_addr  = i_ff;
            state_in = ST_SEG_K0;
         end
         ST_SEG_K0: begin
            cmd.op   = OP_K0;
            state_in = ST_SEG_CLS;
         end
         ST_SEG_CLS: begin
            if (stat.cls_a) begin
               mode_in  = MODE_A;
               state_in = ST_AP_RDA;
            end else if (stat.cls_b) begin
               mode_in  = MODE_B;
               state_in = ST_AP_RDA;
            end else begin
               cmd.op   = OP_DIV_START;
               mode_in  = MODE_T;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_AP_RDA;
         end
         ST_AP_RDA: begin
            cmd.src  = vs_ff;
            rd_addr  = i_ff;
            state_in = ST_AP_A;
         end
         ST_AP_A: begin
            cmd.op   = OP_LOAD_A;
            state_in = (mode_ff == MODE_A) ? ST_AP_WR : ST_AP_RDB;
         end
         ST_AP_RDB: begin
            cmd.src  = vs_ff;
            rd_addr  = IW'(i_p1);
            state_in = ST_AP_B;
         end
         ST_AP_B: begin
            cmd.op   = OP_LOAD_B;
            state_in = (mode_ff == MODE_B) ? ST_AP_WR : ST_AP_MUL;
         end
         ST_AP_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_AP_ADD;
         end
         ST_AP_ADD: begin
            cmd.op   = OP_ADD;
            state_in = ST_AP_WR;
         end
         ST_AP_WR: begin
            if (final_ff) begin
               cmd.op   = OP_RES_Y;
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_WR_COL;
               r_in   = r_ff + 1'b1;
               if ((r_ff + 1'b1) < nr) begin
                  state_in = ST_AP_RDA;
               end else if (func_ff == FUNC_FORWARD) begin
                  final_in = 1'b1;
                  idx_in   = '0;
                  ks_in    = SRC_CMD;
                  vs_in    = SRC_COL;
                  state_in = ST_MM_RD;
               end else begin
                  final_in = 1'b1;
                  state_in = ST_INV0;
               end
            end
         end
         ST_INV0: begin
            cmd.op   = OP_SET_Q;
            cmd.src  = SRC_COL;
            rd_addr  = '0;
            state_in = ST_INV0_CHK;
         end
         ST_INV0_CHK: begin
            if (stat.q_lt_rd) begin
               i_in     = '0;
               state_in = ST_SAT_RD;
            end else begin
               state_in = ST_INV1;
            end
         end
         ST_INV1: begin
            cmd.src  = SRC_COL;
            rd_addr  = IW'(nr - 1'b1);
            state_in = ST_INV1_CHK;
         end
         ST_INV1_CHK: begin
            if (stat.rd_lt_q) begin
               i_in     = IW'(nr - 1'b1);
               state_in = ST_SAT_RD;
            end else begin
               ks_in    = SRC_COL;
               vs_in    = SRC_CMD;
               state_in = ST_SEG_START;
            end
         end
         ST_SAT_RD: begin
            cmd.src  = SRC_CMD;
            rd_addr  = i_ff;
            state_in = ST_SAT_RES;
         end
         ST_SAT_RES: begin
            cmd.op   = OP_RES_SAT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
         mode_ff      <= MODE_A;
         ks_ff        <= SRC_SPD;
         vs_ff        <= SRC_GRID;
         idx_ff       <= '0;
         r_ff         <= '0;
         i_ff         <= '0;
         func_ff      <= FUNC_LD_SPEED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         final_ff     <= final_in;
         mode_ff      <= mode_in;
         ks_ff        <= ks_in;
         vs_ff        <= vs_in;
         idx_ff       <= idx_in;
         r_ff         <= r_in;
         i_ff         <= i_in;
         func_ff      <= func_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the two-dimensional map interpolator core.
`timescale 1ns / 1ps
module tb
   import mi2d_pkg::*;
();

   // Function codes above the forward query are not decoded by the block.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
   localparam int NKEYS = 16;
   localparam int ONE = 32'h0001_0000;

   // One response as the block should present it.
   typedef struct {
      logic [DATA_W-1:0] result;
      logic              ok;
      logic              sat;
   } map_answer_type;

   // Scoreboard: mirrors the map contents and counts, predicts each answer
   // when a request transfer is accepted and compares answers in order.
   class map_scoreboard;
      longint         speed_keys[NKEYS];
      longint         cmd_keys[NKEYS];
      longint         grid[NKEYS*NKEYS];
      int             rows_cfg;
      int             cols_cfg;
      map_answer_type pending[$];
      int             errors;

      function new();
         rows_cfg = 0;
         cols_cfg = 0;
         errors = 0;
      endfunction

      function void write_count(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
         if (idx == CSR_ROWS) rows_cfg = int'(val);
         else rows_cfg = rows_cfg;
         if (idx == CSR_COLS) cols_cfg = int'(val);
      endfunction

      function longint clamp_keys(longint k[NKEYS], int n, longint q);
         longint lo, hi;
         lo = k[0];
         hi = k[0];
         for (int i = 1; i < n; i++) begin
            if (k[i] < lo) lo = k[i];
            if (k[i] > hi) hi = k[i];
         end
         if (q < lo) return lo;
         if (q > hi) return hi;
         return q;
      endfunction

      // Linear interpolation on the first segment whose right key is not below q, else on the last.
      function longint lerp(longint k[NKEYS], longint v[NKEYS], int n, longint q);
         int i;
         longint a, b, num, den, diff;
         longint unsigned frac, mag, prod;
         i = 0;
         if (n <= 1) return v[0];
         while (i + 2 < n && k[i+1] < q) i++;
         a = v[i];
         b = v[i+1];
         den = k[i+1] - k[i];
         num = q - k[i];
         if (den <= 0 || num <= 0) return a;
         if (num >= den) return b;
         frac = (longint'(num) << 31) / longint'(den);
         diff = b - a;
         mag = (diff < 0) ? -diff : diff;
         prod = (mag * frac + (64'd1 << 30)) >> 31;
         return (diff < 0) ? a - longint'(prod) : a + longint'(prod);
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [PIDX_W-1:0] row,
                                 logic [PIDX_W-1:0] col, logic signed [DATA_W-1:0] data,
                                 logic signed [DATA_W-1:0] speed,
                                 logic signed [DATA_W-1:0] qin);
         map_answer_type ans;
         longint column[NKEYS];
         longint cells[NKEYS];
         longint s, c, res;
         int nr, nc;
         nr = (rows_cfg > NKEYS) ? NKEYS : rows_cfg;
         nc = (cols_cfg > NKEYS) ? NKEYS : cols_cfg;
         res = 0;
         ans.ok = 1'b0;
         ans.sat = 1'b0;
         if (func == FUNC_LD_SPEED) begin
            speed_keys[col] = longint'(data);
            ans.ok = 1'b1;
         end else if (func == FUNC_LD_CMD) begin
            cmd_keys[row] = longint'(data);
            ans.ok = 1'b1;
         end else if (func == FUNC_LD_CELL) begin
            grid[row*NKEYS + col] = longint'(data);
            ans.ok = 1'b1;
         end else if ((func == FUNC_INVERSE || func == FUNC_FORWARD) && nr > 0 && nc > 0) begin
            s = clamp_keys(speed_keys, nc, longint'(speed));
            for (int r = 0; r < NKEYS; r++) column[r] = 0;
            for (int r = 0; r < nr; r++) begin
               for (int j = 0; j < NKEYS; j++) cells[j] = grid[r*NKEYS + j];
               column[r] = lerp(speed_keys, cells, nc, s);
            end
            ans.ok = 1'b1;
            if (func == FUNC_INVERSE) begin
               if (longint'(qin) < column[0]) begin
                  res = cmd_keys[0];
                  ans.sat = 1'b1;
               end else if (column[nr-1] < longint'(qin)) begin
                  res = cmd_keys[nr-1];
                  ans.sat = 1'b1;
               end else begin
                  res = lerp(column, cmd_keys, nr, longint'(qin));
               end
            end else begin
               c = clamp_keys(cmd_keys, nr, longint'(qin));
               res = lerp(cmd_keys, column, nr, c);
            end
         end
         ans.result = res[DATA_W-1:0];
         pending.insert(pending.size(), ans);
      endfunction

      function void check_response(logic [DATA_W-1:0] result, logic ok, logic sat);
         map_answer_type exp_ans;
         if (pending.size() == 0) begin
            $display("%0t: response with none outstanding: result %h ok %b saturated %b",
                     $realtime, result, ok, sat);
            errors++;
            return;
         end
         exp_ans = pending.pop_front();
         if (result !== exp_ans.result) begin
            $display("%0t: result expected %h actual %h", $realtime, exp_ans.result, result);
            errors++;
         end
         if (ok !== exp_ans.ok) begin
            $display("%0t: ok expected %b actual %b", $realtime, exp_ans.ok, ok);
            errors++;
         end
         if (sat !== exp_ans.sat) begin
            $display("%0t: saturated expected %b actual %b", $realtime, exp_ans.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func;
   logic [PIDX_W-1:0]        req_row;
   logic [PIDX_W-1:0]        req_col;
   logic signed [DATA_W-1:0] req_load_data;
   logic signed [DATA_W-1:0] req_query_speed;
   logic signed [DATA_W-1:0] req_query_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_result;
   logic                     rsp_ok;
   logic                     rsp_saturated;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CNT_W-1:0]         csr_wdata;

   map_scoreboard sb;
   int            tx_idle_pct;
   int            rx_idle_pct;

   map_interpolator_2d_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_load_data  (req_load_data),
      .req_query_speed(req_query_speed),
      .req_query_in   (req_query_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result     (rsp_result),
      .rsp_ok         (rsp_ok),
      .rsp_saturated  (rsp_saturated),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is bounded by a fixed time well above the slowest correct run.
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Every accepted response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_result, rsp_ok, rsp_saturated);
      end
   end

   // Drive one request and hold it until the block takes it. Valid stays high
   // after the transfer so that back-to-back requests need no gap; a random
   // idle period lowers it first.
   task automatic send_req(logic [FUNC_W-1:0] func, logic [PIDX_W-1:0] row,
                           logic [PIDX_W-1:0] col, logic [DATA_W-1:0] data,
                           logic [DATA_W-1:0] speed, logic [DATA_W-1:0] qin);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_row         <= row;
      req_col         <= col;
      req_load_data   <= data;
      req_query_speed <= speed;
      req_query_in    <= qin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(func, row, col, data, speed, qin);
   endtask

   // Pause the sender until every predicted response has arrived. Every request
   // yields a response, so a short settle afterwards is enough.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_counts(int rows, int cols);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows[CNT_W-1:0];
      @(posedge clock);
      sb.write_count(CSR_ROWS, rows[CNT_W-1:0]);
      csr_index <= CSR_COLS;
      csr_wdata <= cols[CNT_W-1:0];
      @(posedge clock);
      sb.write_count(CSR_COLS, cols[CNT_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly values near the working range of the map, sometimes any 32 bits.
   function automatic logic [DATA_W-1:0] near_value(int lo_units, int hi_units, int wild_pct);
      if ($urandom_range(99) < wild_pct) return $urandom;
      return $urandom_range(0, (hi_units - lo_units) * ONE) + lo_units * ONE;
   endfunction

   // One random request. Breakpoint loads mostly keep the keys roughly
   // increasing so that queries land inside real segments; the rest is noise.
   task automatic random_req;
      int                  pick;
      logic [PIDX_W-1:0]   row;
      logic [PIDX_W-1:0]   col;
      logic [DATA_W-1:0]   data;
      logic [FUNC_W-1:0]   func;
      pick = $urandom_range(99);
      row  = PIDX_W'($urandom_range(15));
      col  = PIDX_W'($urandom_range(15));
      data = $urandom;
      if (pick < 8) begin
         if ($urandom_range(99) < 75) data = col * 2 * ONE + $urandom_range(0, ONE);
         send_req(FUNC_LD_SPEED, row, col, data, $urandom, $urandom);
      end else if (pick < 16) begin
         if ($urandom_range(99) < 75) data = row * 2 * ONE - 4 * ONE + $urandom_range(0, ONE);
         send_req(FUNC_LD_CMD, row, col, data, $urandom, $urandom);
      end else if (pick < 30) begin
         if ($urandom_range(99) < 80) data = row * ONE / 2 + $urandom_range(0, ONE / 4);
         send_req(FUNC_LD_CELL, row, col, data, $urandom, $urandom);
      end else if (pick < 94) begin
         func = $urandom_range(1) ? FUNC_FORWARD : FUNC_INVERSE;
         send_req(func, row, col, data, near_value(-2, 34, 15),
                  (func == FUNC_FORWARD) ? near_value(-6, 28, 15) : near_value(-1, 9, 15));
      end else begin
         send_req(FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)), row, col, data,
                  $urandom, $urandom);
      end
   endtask

   initial begin
      int rows_set[8];
      int cols_set[8];
      sb = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_LD_SPEED;
      req_row         = '0;
      req_col         = '0;
      req_load_data   = '0;
      req_query_speed = '0;
      req_query_in    = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_ROWS;
      csr_wdata       = '0;
      tx_idle_pct     = 0;
      rx_idle_pct     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty map after reset: queries answer with ok low, unused codes also answer with ok low.
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, 32'h7fff_ffff, 32'h8000_0000);
      send_req(FUNC_FORWARD, 4'd15, 4'd15, '1, 32'h8000_0000, 32'h7fff_ffff);
      for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
         send_req(FUNC_W'(f), 4'd15, 4'd0, '1, '1, '1);

      // Fill every key and cell so that no query ever reads an unwritten entry.
      for (int i = 0; i < NKEYS; i++) begin
         send_req(FUNC_LD_SPEED, 4'd0, PIDX_W'(i), i * 2 * ONE, '0, '0);
         send_req(FUNC_LD_CMD, PIDX_W'(i), 4'd0, i * 2 * ONE - 4 * ONE, '0, '0);
      end
      for (int r = 0; r < NKEYS; r++)
         for (int c = 0; c < NKEYS; c++)
            send_req(FUNC_LD_CELL, PIDX_W'(r), PIDX_W'(c), r * ONE / 2 + c * (ONE / 16),
                     '0, '0);

      // A register written with zero on one axis still means an empty map.
      write_counts(0, 16);
      send_req(FUNC_FORWARD, 4'd0, 4'd0, '0, ONE, ONE);
      write_counts(16, 0);
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, ONE, ONE);

      // Full map: extreme speeds and inputs, exact keys and both saturation sides.
      write_counts(16, 16);
      send_req(FUNC_FORWARD, 4'd0, 4'd0, '0, 32'h8000_0000, 32'h8000_0000);
      send_req(FUNC_FORWARD, 4'd0, 4'd0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_req(FUNC_FORWARD, 4'd0, 4'd0, '0, 6 * ONE, 8 * ONE);
      send_req(FUNC_FORWARD, 4'd0, 4'd0, '0, 5 * ONE + 123, 3 * ONE + 4567);
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, 32'h8000_0000, 32'h8000_0000);
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, 10 * ONE, 3 * ONE + 777);
      send_req(FUNC_INVERSE, 4'd0, 4'd0, '0, 0, 0);

      // Later phases cover single keys, one axis only and counts above the bound.
      rows_set = '{16, 1, 1, 16, 31, 17, 5, 2};
      cols_set = '{16, 1, 16, 1, 31, 3, 16, 30};
      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            tx_idle_pct = 20;
            rx_idle_pct = 77;
         end else if (ph < 6) begin
            tx_idle_pct = 77;
            rx_idle_pct = 20;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (ph < 8) write_counts(rows_set[ph], cols_set[ph]);
         else write_counts($urandom_range(0, 31), $urandom_range(0, 31));
         for (int n = 0; n < 170; n++) random_req();
      end

      drain();
      repeat (400) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mi2d_pkg.sv
rtl/mi2d_div.sv
rtl/mi2d_dp.sv
rtl/mi2d_ctrl.sv
rtl/map_interpolator_2d_core.sv
tb/tb.sv
